// File: hdl/elastic_collision_response_assert.svh
// Assertion shorthands for the checker of this block.
// Both sample on clk and are off while arst_n is low.
`ifndef ELASTIC_COLLISION_RESPONSE_ASSERT_SVH
`define ELASTIC_COLLISION_RESPONSE_ASSERT_SVH

// Same-cycle implication.
`define ECR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ECR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ecr_pkg.sv
package ecr_pkg;

	localparam int IDX_W  = 12;
	localparam int POS_W  = 16;
	localparam int VEL_W  = 16;
	// position and velocity differences
	localparam int DIFF_W = POS_W + 1;
	// one squared difference, always below 2^32
	localparam int SQ_W   = 2 * POS_W;
	localparam int DD_W   = SQ_W + 1;
	// one dv*d product, signed
	localparam int PROD_W = SQ_W + 1;
	localparam int DOT_W  = PROD_W + 1;
	// dot * d, signed, magnitude below 2^49
	localparam int MAG_W  = DOT_W + POS_W - 1;
	localparam int NUM_W  = MAG_W + 1;
	// the impulse never exceeds |dv|, so 17 quotient bits are enough
	localparam int QUO_W  = VEL_W + 1;
	localparam int SUM_W  = VEL_W + 3;

	localparam int GEOM_STAGES = 5;
	localparam int DEPTH       = GEOM_STAGES + QUO_W + 1;
	localparam int OCC_W       = $clog2(DEPTH + 1);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (VEL_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (VEL_W - 1)));

	typedef struct packed {
		logic        [IDX_W-1:0] idx_a;
		logic        [IDX_W-1:0] idx_b;
		logic        [POS_W-1:0] pos_ax;
		logic        [POS_W-1:0] pos_ay;
		logic        [POS_W-1:0] pos_bx;
		logic        [POS_W-1:0] pos_by;
		logic signed [VEL_W-1:0] vel_ax;
		logic signed [VEL_W-1:0] vel_ay;
		logic signed [VEL_W-1:0] vel_bx;
		logic signed [VEL_W-1:0] vel_by;
	} pair_t;

	typedef struct packed {
		logic        [IDX_W-1:0] idx_a;
		logic        [IDX_W-1:0] idx_b;
		logic signed [VEL_W-1:0] vel_ax;
		logic signed [VEL_W-1:0] vel_ay;
		logic signed [VEL_W-1:0] vel_bx;
		logic signed [VEL_W-1:0] vel_by;
		logic                    coinc;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [DD_W-1:0]   dd;
		logic [MAG_W-1:0]  rem_x;
		logic [MAG_W-1:0]  rem_y;
		logic              neg_x;
		logic              neg_y;
		logic [QUO_W-1:0]  quo_x;
		logic [QUO_W-1:0]  quo_y;
	} div_t;

	typedef struct packed {
		logic        [IDX_W-1:0] idx_a;
		logic        [IDX_W-1:0] idx_b;
		logic signed [VEL_W-1:0] vel_ax;
		logic signed [VEL_W-1:0] vel_ay;
		logic signed [VEL_W-1:0] vel_bx;
		logic signed [VEL_W-1:0] vel_by;
		logic                    coinc;
		logic                    clipped;
	} res_t;

endpackage

// File: hdl/ecr_if.sv
interface ecr_in_if;
	logic                            valid;
	logic                            ready;
	logic        [ecr_pkg::IDX_W-1:0] index_a;
	logic        [ecr_pkg::IDX_W-1:0] index_b;
	logic        [ecr_pkg::POS_W-1:0] pos_a_x;
	logic        [ecr_pkg::POS_W-1:0] pos_a_y;
	logic        [ecr_pkg::POS_W-1:0] pos_b_x;
	logic        [ecr_pkg::POS_W-1:0] pos_b_y;
	logic signed [ecr_pkg::VEL_W-1:0] vel_a_x;
	logic signed [ecr_pkg::VEL_W-1:0] vel_a_y;
	logic signed [ecr_pkg::VEL_W-1:0] vel_b_x;
	logic signed [ecr_pkg::VEL_W-1:0] vel_b_y;

	modport source (
		output valid, index_a, index_b, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
		       vel_a_x, vel_a_y, vel_b_x, vel_b_y,
		input  ready
	);
	modport sink (
		input  valid, index_a, index_b, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
		       vel_a_x, vel_a_y, vel_b_x, vel_b_y,
		output ready
	);
endinterface

interface ecr_out_if;
	logic                            valid;
	logic                            ready;
	logic        [ecr_pkg::IDX_W-1:0] out_index_a;
	logic        [ecr_pkg::IDX_W-1:0] out_index_b;
	logic signed [ecr_pkg::VEL_W-1:0] new_vel_a_x;
	logic signed [ecr_pkg::VEL_W-1:0] new_vel_a_y;
	logic signed [ecr_pkg::VEL_W-1:0] new_vel_b_x;
	logic signed [ecr_pkg::VEL_W-1:0] new_vel_b_y;
	logic                            coincident;
	logic                            clipped;

	modport source (
		output valid, out_index_a, out_index_b, new_vel_a_x, new_vel_a_y,
		       new_vel_b_x, new_vel_b_y, coincident, clipped,
		input  ready
	);
	modport sink (
		input  valid, out_index_a, out_index_b, new_vel_a_x, new_vel_a_y,
		       new_vel_b_x, new_vel_b_y, coincident, clipped,
		output ready
	);
endinterface

// File: hdl/ecr_geom.sv
module ecr_geom (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ecr_pkg::pair_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ecr_pkg::div_t  out_data
);
	import ecr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic        [SQ_W-1:0]   sqx_s2, sqy_s2;
	logic signed [PROD_W-1:0] prx_s2, pry_s2;
	logic        [DD_W-1:0]   dd_s3, dd_s4, dd_s5;
	logic signed [DOT_W-1:0]  dot_s3;
	logic signed [NUM_W-1:0]  nx_s4, ny_s4;
	logic        [MAG_W-1:0]  magx_s5, magy_s5;
	logic                     negx_s5, negy_s5;

	logic signed [2*DIFF_W-1:0]      sqx_w, sqy_w, prx_w, pry_w;
	logic signed [DOT_W+DIFF_W-1:0]  nx_w, ny_w;
	logic        [NUM_W-1:0]         absx_w, absy_w;

	// a stage loads when it is empty or its content moves on
	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign sqx_w  = dx_s1 * dx_s1;
	assign sqy_w  = dy_s1 * dy_s1;
	assign prx_w  = dvx_s1 * dx_s1;
	assign pry_w  = dvy_s1 * dy_s1;
	assign nx_w   = dot_s3 * dx_s3;
	assign ny_w   = dot_s3 * dy_s3;
	assign absx_w = nx_s4[NUM_W-1] ? NUM_W'(-nx_s4) : NUM_W'(nx_s4);
	assign absy_w = ny_s4[NUM_W-1] ? NUM_W'(-ny_s4) : NUM_W'(ny_s4);

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1  <= $signed({1'b0, in_data.pos_ax}) - $signed({1'b0, in_data.pos_bx});
			dy_s1  <= $signed({1'b0, in_data.pos_ay}) - $signed({1'b0, in_data.pos_by});
			dvx_s1 <= $signed({in_data.vel_ax[VEL_W-1], in_data.vel_ax})
			        - $signed({in_data.vel_bx[VEL_W-1], in_data.vel_bx});
			dvy_s1 <= $signed({in_data.vel_ay[VEL_W-1], in_data.vel_ay})
			        - $signed({in_data.vel_by[VEL_W-1], in_data.vel_by});
			side_s1.idx_a  <= in_data.idx_a;
			side_s1.idx_b  <= in_data.idx_b;
			side_s1.vel_ax <= in_data.vel_ax;
			side_s1.vel_ay <= in_data.vel_ay;
			side_s1.vel_bx <= in_data.vel_bx;
			side_s1.vel_by <= in_data.vel_by;
			side_s1.coinc  <= (in_data.pos_ax == in_data.pos_bx)
			               && (in_data.pos_ay == in_data.pos_by);
		end
		if (en2) begin
			sqx_s2  <= sqx_w[SQ_W-1:0];
			sqy_s2  <= sqy_w[SQ_W-1:0];
			prx_s2  <= prx_w[PROD_W-1:0];
			pry_s2  <= pry_w[PROD_W-1:0];
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			side_s2 <= side_s1;
		end
		if (en3) begin
			dd_s3   <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			dot_s3  <= DOT_W'(prx_s2) + DOT_W'(pry_s2);
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			side_s3 <= side_s2;
		end
		if (en4) begin
			nx_s4   <= nx_w[NUM_W-1:0];
			ny_s4   <= ny_w[NUM_W-1:0];
			dd_s4   <= dd_s3;
			side_s4 <= side_s3;
		end
		if (en5) begin
			// the numerator is -(dot*d): its sign is negative when dot*d is positive
			negx_s5 <= !nx_s4[NUM_W-1] && (nx_s4 != '0);
			negy_s5 <= !ny_s4[NUM_W-1] && (ny_s4 != '0);
			magx_s5 <= absx_w[MAG_W-1:0];
			magy_s5 <= absy_w[MAG_W-1:0];
			dd_s5   <= dd_s4;
			side_s5 <= side_s4;
		end
	end

	assign out_valid      = v_s5;
	assign out_data.side  = side_s5;
	assign out_data.dd    = dd_s5;
	assign out_data.rem_x = magx_s5;
	assign out_data.rem_y = magy_s5;
	assign out_data.neg_x = negx_s5;
	assign out_data.neg_y = negy_s5;
	assign out_data.quo_x = '0;
	assign out_data.quo_y = '0;

endmodule

// File: hdl/ecr_div.sv
module ecr_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ecr_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ecr_pkg::div_t out_data
);
	import ecr_pkg::*;

	// one quotient bit per stage, most significant first, both axes side by side
	logic [QUO_W-1:0] v_s;
	logic [QUO_W-1:0] en;
	div_t             pipe_s  [QUO_W];
	div_t             stage_in[QUO_W];
	div_t             stage_nx[QUO_W];

	assign stage_in[0] = in_data;
	assign in_ready    = en[0];
	assign out_valid   = v_s[QUO_W-1];
	assign out_data    = pipe_s[QUO_W-1];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		localparam int SH = QUO_W - 1 - j;

		logic [MAG_W:0] dsh;
		logic [MAG_W:0] tx;
		logic [MAG_W:0] ty;

		if (j > 0) begin : g_link
			assign stage_in[j] = pipe_s[j-1];
		end

		if (j == QUO_W - 1) begin : g_last
			assign en[j] = !v_s[j] || out_ready;
		end else begin : g_mid
			assign en[j] = !v_s[j] || en[j+1];
		end

		assign dsh = (MAG_W + 1)'(stage_in[j].dd) << SH;
		assign tx  = {1'b0, stage_in[j].rem_x} - dsh;
		assign ty  = {1'b0, stage_in[j].rem_y} - dsh;

		// keep the trial difference where it did not go negative
		always_comb begin
			stage_nx[j] = stage_in[j];
			if (!tx[MAG_W]) begin
				stage_nx[j].rem_x     = tx[MAG_W-1:0];
				stage_nx[j].quo_x[SH] = 1'b1;
			end
			if (!ty[MAG_W]) begin
				stage_nx[j].rem_y     = ty[MAG_W-1:0];
				stage_nx[j].quo_y[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en[j]) begin
				v_s[j] <= (j == 0) ? in_valid : v_s[(j == 0) ? 0 : j - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				pipe_s[j] <= stage_nx[j];
			end
		end
	end

endmodule

// File: hdl/ecr_final.sv
module ecr_final (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ecr_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ecr_pkg::res_t out_data
);
	import ecr_pkg::*;

	logic                    en;
	logic                    v_s;
	res_t                    res_s;
	logic signed [QUO_W:0]   kx_w, ky_w;
	logic signed [SUM_W-1:0] sax_w, say_w, sbx_w, sby_w;
	logic        [VEL_W:0]   rax_w, ray_w, rbx_w, rby_w;

	// returns {clip, value}
	function automatic logic [VEL_W:0] sat_vel(input logic signed [SUM_W-1:0] v);
		logic [VEL_W:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[VEL_W-1:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[VEL_W-1:0]};
		end else begin
			r = {1'b0, v[VEL_W-1:0]};
		end
		return r;
	endfunction

	assign en        = !v_s || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s;
	assign out_data  = res_s;

	assign kx_w  = in_data.neg_x ? -$signed({1'b0, in_data.quo_x}) : $signed({1'b0, in_data.quo_x});
	assign ky_w  = in_data.neg_y ? -$signed({1'b0, in_data.quo_y}) : $signed({1'b0, in_data.quo_y});
	assign sax_w = SUM_W'(in_data.side.vel_ax) + SUM_W'(kx_w);
	assign say_w = SUM_W'(in_data.side.vel_ay) + SUM_W'(ky_w);
	assign sbx_w = SUM_W'(in_data.side.vel_bx) - SUM_W'(kx_w);
	assign sby_w = SUM_W'(in_data.side.vel_by) - SUM_W'(ky_w);
	assign rax_w = sat_vel(sax_w);
	assign ray_w = sat_vel(say_w);
	assign rbx_w = sat_vel(sbx_w);
	assign rby_w = sat_vel(sby_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (en) begin
			v_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.idx_a <= in_data.side.idx_a;
			res_s.idx_b <= in_data.side.idx_b;
			res_s.coinc <= in_data.side.coinc;
			// pass velocities through untouched when the centers coincide
			if (in_data.side.coinc) begin
				res_s.vel_ax  <= in_data.side.vel_ax;
				res_s.vel_ay  <= in_data.side.vel_ay;
				res_s.vel_bx  <= in_data.side.vel_bx;
				res_s.vel_by  <= in_data.side.vel_by;
				res_s.clipped <= 1'b0;
			end else begin
				res_s.vel_ax  <= rax_w[VEL_W-1:0];
				res_s.vel_ay  <= ray_w[VEL_W-1:0];
				res_s.vel_bx  <= rbx_w[VEL_W-1:0];
				res_s.vel_by  <= rby_w[VEL_W-1:0];
				res_s.clipped <= rax_w[VEL_W] | ray_w[VEL_W] | rbx_w[VEL_W] | rby_w[VEL_W];
			end
		end
	end

endmodule

// File: hdl/elastic_collision_response.sv
// Pipeline: 5 geometry stages, 17 divider stages (one quotient bit each) and 1 output
// stage between acceptance of a pair and its result on the output.
// Throughput: one pair per cycle; a stall fills empty stages before it holds input.
// Reset clears only the valid bits of the stages; data registers are not reset.
module elastic_collision_response (
	input logic      clk,
	input logic      arst_n,
	ecr_in_if.sink   pair,
	ecr_out_if.source result
);
	import ecr_pkg::*;

	pair_t pair_data;
	div_t  geom_data, div_data;
	res_t  res_data;
	logic  geom_valid, geom_ready;
	logic  div_valid, div_ready;

	assign pair_data.idx_a  = pair.index_a;
	assign pair_data.idx_b  = pair.index_b;
	assign pair_data.pos_ax = pair.pos_a_x;
	assign pair_data.pos_ay = pair.pos_a_y;
	assign pair_data.pos_bx = pair.pos_b_x;
	assign pair_data.pos_by = pair.pos_b_y;
	assign pair_data.vel_ax = pair.vel_a_x;
	assign pair_data.vel_ay = pair.vel_a_y;
	assign pair_data.vel_bx = pair.vel_b_x;
	assign pair_data.vel_by = pair.vel_b_y;

	ecr_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pair.valid),
		.in_ready  (pair.ready),
		.in_data   (pair_data),
		.out_valid (geom_valid),
		.out_ready (geom_ready),
		.out_data  (geom_data)
	);

	ecr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geom_valid),
		.in_ready  (geom_ready),
		.in_data   (geom_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	ecr_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

	assign result.out_index_a = res_data.idx_a;
	assign result.out_index_b = res_data.idx_b;
	assign result.new_vel_a_x = res_data.vel_ax;
	assign result.new_vel_a_y = res_data.vel_ay;
	assign result.new_vel_b_x = res_data.vel_bx;
	assign result.new_vel_b_y = res_data.vel_by;
	assign result.coincident  = res_data.coinc;
	assign result.clipped     = res_data.clipped;

endmodule

// File: hdl/ecr_checker.sv
`include "elastic_collision_response_assert.svh"

module ecr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pair_valid,
	input logic                            pair_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic        [ecr_pkg::IDX_W-1:0] result_index_a,
	input logic signed [ecr_pkg::VEL_W-1:0] result_vel_a_x,
	input logic signed [ecr_pkg::VEL_W-1:0] result_vel_b_y,
	input logic                            result_coincident,
	input logic                            result_clipped
);
	import ecr_pkg::*;

	logic [OCC_W-1:0] occ_q;
	logic             in_acc, out_acc;

	assign in_acc  = pair_valid && pair_ready;
	assign out_acc = result_valid && result_ready;

	// count items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_acc) - OCC_W'(out_acc);
		end
	end

	`ECR_ASSERT_NXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(result_index_a) && $stable(result_vel_a_x) && $stable(result_vel_b_y) && $stable(result_coincident), "stalled result changed")
	`ECR_ASSERT_IMP(a_coinc_no_clip, result_valid && result_coincident, !result_clipped, "coincident result flagged as clipped")
	`ECR_ASSERT_IMP(a_no_phantom, result_valid, occ_q != '0, "result without an item in flight")
	`ECR_ASSERT_IMP(a_room_ready, occ_q < OCC_W'(DEPTH), pair_ready, "input held while the pipeline has room")

endmodule

bind elastic_collision_response ecr_checker u_ecr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.pair_valid        (pair.valid),
	.pair_ready        (pair.ready),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_index_a    (result.out_index_a),
	.result_vel_a_x    (result.new_vel_a_x),
	.result_vel_b_y    (result.new_vel_b_y),
	.result_coincident (result.coincident),
	.result_clipped    (result.clipped)
);

// File: tb/sv/elastic_collision_response_checker.sv
`timescale 1ns / 1ps

module elastic_collision_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	ecr_in_if           pair,
	ecr_out_if          result,
	output int unsigned mismatches,
	output int unsigned pending
);
	import ecr_pkg::*;

	localparam longint VEL_MAX = (longint'(1) <<< (VEL_W - 1)) - 1;
	localparam longint VEL_MIN = -VEL_MAX - 1;

	res_t due_responses[$];

	function automatic logic signed [VEL_W-1:0] clamp_vel(input longint v, inout logic clip);
		logic signed [VEL_W-1:0] r;
		if (v > VEL_MAX) begin
			clip = 1'b1;
			r = VEL_MAX[VEL_W-1:0];
		end else if (v < VEL_MIN) begin
			clip = 1'b1;
			r = VEL_MIN[VEL_W-1:0];
		end else begin
			r = v[VEL_W-1:0];
		end
		return r;
	endfunction

	// impulse along the line of centers, quotient truncated toward zero, then clamped
	function automatic res_t resolve_collision(input pair_t p);
		longint vax, vay, vbx, vby;
		longint dx, dy, dd, dot, kx, ky;
		logic clip;
		res_t r;
		vax = longint'($signed(p.vel_ax));
		vay = longint'($signed(p.vel_ay));
		vbx = longint'($signed(p.vel_bx));
		vby = longint'($signed(p.vel_by));
		dx = longint'(p.pos_ax) - longint'(p.pos_bx);
		dy = longint'(p.pos_ay) - longint'(p.pos_by);
		dd = dx * dx + dy * dy;
		clip = 1'b0;
		r.idx_a = p.idx_a;
		r.idx_b = p.idx_b;
		if (dd == 0) begin
			r.vel_ax = p.vel_ax;
			r.vel_ay = p.vel_ay;
			r.vel_bx = p.vel_bx;
			r.vel_by = p.vel_by;
			r.coinc = 1'b1;
		end else begin
			dot = (vax - vbx) * dx + (vay - vby) * dy;
			kx = (-(dot * dx)) / dd;
			ky = (-(dot * dy)) / dd;
			r.vel_ax = clamp_vel(vax + kx, clip);
			r.vel_ay = clamp_vel(vay + ky, clip);
			r.vel_bx = clamp_vel(vbx - kx, clip);
			r.vel_by = clamp_vel(vby - ky, clip);
			r.coinc = 1'b0;
		end
		r.clipped = clip;
		return r;
	endfunction

	function automatic string describe(input res_t r);
		return $sformatf("idx %0d/%0d a (%0d,%0d) b (%0d,%0d) coinc %0b clip %0b",
			r.idx_a, r.idx_b, r.vel_ax, r.vel_ay, r.vel_bx, r.vel_by, r.coinc, r.clipped);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_t item;
		res_t got;
		res_t want;
		if (!arst_n) begin
			due_responses.delete();
			pending = 0;
		end else begin
			if (pair.valid && pair.ready) begin
				item.idx_a  = pair.index_a;
				item.idx_b  = pair.index_b;
				item.pos_ax = pair.pos_a_x;
				item.pos_ay = pair.pos_a_y;
				item.pos_bx = pair.pos_b_x;
				item.pos_by = pair.pos_b_y;
				item.vel_ax = pair.vel_a_x;
				item.vel_ay = pair.vel_a_y;
				item.vel_bx = pair.vel_b_x;
				item.vel_by = pair.vel_b_y;
				due_responses.insert(due_responses.size(), resolve_collision(item));
			end
			if (result.valid && result.ready) begin
				got.idx_a   = result.out_index_a;
				got.idx_b   = result.out_index_b;
				got.vel_ax  = result.new_vel_a_x;
				got.vel_ay  = result.new_vel_a_y;
				got.vel_bx  = result.new_vel_b_x;
				got.vel_by  = result.new_vel_b_y;
				got.coinc   = result.coincident;
				got.clipped = result.clipped;
				if (due_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected item: %s", $time, describe(got));
				end else begin
					want = due_responses.pop_front();
					if (got.idx_a !== want.idx_a || got.idx_b !== want.idx_b ||
					    got.vel_ax !== want.vel_ax || got.vel_ay !== want.vel_ay ||
					    got.vel_bx !== want.vel_bx || got.vel_by !== want.vel_by ||
					    got.coinc !== want.coinc || got.clipped !== want.clipped) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch, expected %s", $time, describe(want));
							$display("%0t:           actual   %s", $time, describe(got));
						end
					end
				end
			end
			pending = due_responses.size();
		end
	end

endmodule

// File: tb/sv/elastic_collision_response_tb.sv
`timescale 1ns / 1ps

module elastic_collision_response_tb;
	import ecr_pkg::*;

	localparam int RANDOM_PAIRS = 1830;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned sent = 0;
	int unsigned burst_left = 0;
	bit          squeezed = 1'b0;

	ecr_in_if  pair_if ();
	ecr_out_if res_if ();

	elastic_collision_response u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_if),
		.result (res_if)
	);

	elastic_collision_response_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair_if),
		.result     (res_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("elastic_collision_response test failed");
		$finish;
	end

	function automatic logic signed [VEL_W-1:0] pick_vel();
		logic signed [VEL_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'sh7fff;
			1: v = 16'sh8000;
			2: v = 16'sh0000;
			3: v = 16'shffff;
			4, 5: v = VEL_W'($urandom_range(0, 2047)) - 16'sd1024;
			default: v = VEL_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		p.idx_a  = IDX_W'($urandom_range(0, 4095));
		p.idx_b  = ($urandom_range(0, 7) == 0) ? p.idx_a : IDX_W'($urandom_range(0, 4095));
		p.pos_ax = POS_W'($urandom);
		p.pos_ay = POS_W'($urandom);
		p.pos_bx = POS_W'($urandom);
		p.pos_by = POS_W'($urandom);
		if (kind < 30) begin
			// near neighbors, the usual case from a collision search
			p.pos_bx = p.pos_ax + POS_W'($urandom_range(0, 128)) - 16'd64;
			p.pos_by = p.pos_ay + POS_W'($urandom_range(0, 128)) - 16'd64;
		end else if (kind < 36) begin
			p.pos_bx = p.pos_ax;
			p.pos_by = p.pos_ay;
		end else if (kind < 41) begin
			p.pos_by = p.pos_ay;
		end else if (kind < 46) begin
			p.pos_bx = p.pos_ax;
		end
		p.vel_ax = pick_vel();
		p.vel_ay = pick_vel();
		p.vel_bx = pick_vel();
		p.vel_by = pick_vel();
		return p;
	endfunction

	task automatic drive_fields(input pair_t p);
		pair_if.index_a <= p.idx_a;
		pair_if.index_b <= p.idx_b;
		pair_if.pos_a_x <= p.pos_ax;
		pair_if.pos_a_y <= p.pos_ay;
		pair_if.pos_b_x <= p.pos_bx;
		pair_if.pos_b_y <= p.pos_by;
		pair_if.vel_a_x <= p.vel_ax;
		pair_if.vel_a_y <= p.vel_ay;
		pair_if.vel_b_x <= p.vel_bx;
		pair_if.vel_b_y <= p.vel_by;
	endtask

	task automatic idle(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			pair_if.valid <= 1'b0;
			drive_fields(random_pair());
		end
	endtask

	task automatic offer_pair(input pair_t p);
		if (burst_left == 0) begin
			idle($urandom_range(0, 9));
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                        : $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		pair_if.valid <= 1'b1;
		drive_fields(p);
		do @(posedge clk); while (!pair_if.ready);
		sent++;
	endtask

	// receiver: randomly chosen stall patterns, plus one long hold-off
	initial begin
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned mode;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeezed && sent >= 400) begin
				squeezed = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
					0: res_if.ready <= 1'b1;
					1: res_if.ready <= ($urandom_range(0, 3) != 0);
					default: res_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		pair_if.valid   = 1'b0;
		pair_if.index_a = '0;
		pair_if.index_b = '0;
		pair_if.pos_a_x = '0;
		pair_if.pos_a_y = '0;
		pair_if.pos_b_x = '0;
		pair_if.pos_b_y = '0;
		pair_if.vel_a_x = '0;
		pair_if.vel_a_y = '0;
		pair_if.vel_b_x = '0;
		pair_if.vel_b_y = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// coincident pairs, zero and extreme velocities, same index twice
		offer_pair(pair_t'{12'd0, 12'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
		offer_pair(pair_t'{12'd4095, 12'd4095, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
		offer_pair(pair_t'{12'd2048, 12'd2047, 16'h4d2e, 16'h162e, 16'h4d2e, 16'h162e,
			16'sh0123, 16'shfedc, 16'sh8000, 16'sh7fff});
		// motion along the line of centers on one axis at full span
		offer_pair(pair_t'{12'd0, 12'd4095, 16'hffff, 16'h0000, 16'h0000, 16'h0000,
			16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000});
		offer_pair(pair_t'{12'd4095, 12'd0, 16'h0000, 16'hffff, 16'h0000, 16'h0000,
			16'sh0000, 16'sh8000, 16'sh0000, 16'sh7fff});
		// relative motion across the line of centers (no impulse), then at 45 degrees to it
		offer_pair(pair_t'{12'd1, 12'd2, 16'hffff, 16'hffff, 16'h0000, 16'h0000,
			16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
		offer_pair(pair_t'{12'd9, 12'd10, 16'h0000, 16'hffff, 16'hffff, 16'h0000,
			16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000});
		// saturating results, then extreme velocities with no impulse
		offer_pair(pair_t'{12'd3, 12'd3, 16'h0010, 16'h0010, 16'h0000, 16'h0000,
			16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
		offer_pair(pair_t'{12'd11, 12'd12, 16'h0100, 16'h0080, 16'h0000, 16'h0000,
			16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
		offer_pair(pair_t'{12'd13, 12'd14, 16'h0001, 16'h0001, 16'h0000, 16'h0000,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
		// smallest separations
		offer_pair(pair_t'{12'd5, 12'd6, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
			16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000});
		offer_pair(pair_t'{12'd7, 12'd8, 16'd100, 16'd100, 16'd101, 16'd101,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
		offer_pair(pair_t'{12'd15, 12'd16, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
			16'shffff, 16'shffff, 16'sh0001, 16'sh0001});
		// quotient truncation toward zero for both signs
		offer_pair(pair_t'{12'd17, 12'd18, 16'h0003, 16'h0001, 16'h0000, 16'h0000,
			16'sh0007, 16'shfffb, 16'sh0000, 16'sh0000});
		offer_pair(pair_t'{12'd19, 12'd20, 16'h0000, 16'h0000, 16'h0003, 16'h0001,
			16'shfff9, 16'sh0005, 16'sh0000, 16'sh0000});
		offer_pair(pair_t'{12'd4000, 12'd100, 16'h0005, 16'h0007, 16'h0002, 16'h0003,
			16'sh0000, 16'sh0000, 16'sh0031, 16'shffd3});

		repeat (RANDOM_PAIRS) offer_pair(random_pair());
		idle(1);

		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("elastic_collision_response test passed");
		else
			$display("elastic_collision_response test failed");
		$finish;
	end

endmodule
